### sv/wfba_pkg.sv
package wfba_pkg;

  localparam int ADDR_W   = 20;
  localparam int REQ_W    = 12;
  localparam int ORDER_W  = 32;
  localparam int STATUS_W = 2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_PAGES   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE   = 2'd3;

endpackage

### sv/wfba_if.sv
interface wfba_req_if import wfba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [REQ_W-1:0]  request_size;
  logic [ADDR_W-1:0] address;

  modport source (output valid, action, request_size, address, input ready);
  modport sink (input valid, action, request_size, address, output ready);
endinterface

interface wfba_rsp_if import wfba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   address_res;
  logic                new_page;
  logic [STATUS_W-1:0] status;

  modport source (output valid, address_res, new_page, status, input ready);
  modport sink (input valid, address_res, new_page, status, output ready);
endinterface

### sv/worst_fit_block_allocator.sv
// worst-fit block allocator
// requests come in on req_i: action 0 allocates request_size bytes, action 1 frees the
// block whose payload address is given. each request gives one response on rsp_o with
// the payload address (allocate only), a new-page flag and a status code.
// a request is taken only when the block is idle; it then scans the whole block table
// through one read port of the table memory, one entry per cycle, keeping the best
// candidate, the two lowest unused entries and the matching entry in registers.
// after the scan a drain step, a decision step and up to two table writes follow,
// then the response step; the next request is taken after the response is loaded
// into the output register.
// the response register holds its value while the receiver stalls; a finished
// request waits in its last step until the register is free.
// reset clears the entry valid and free flags, the push counter and the page count,
// so the table starts empty; no clearing pass is needed.
module worst_fit_block_allocator import wfba_pkg::*; #(
  parameter int TABLE_ENTRIES = 64,
  parameter int PAGES         = 256,
  parameter int PAGE_BYTES    = 4096,
  parameter int HEADER_BYTES  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wfba_req_if.sink    req_i,
  wfba_rsp_if.source  rsp_o
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int SZ_W  = $clog2(PAGE_BYTES);
  localparam int PG_W  = $clog2(PAGES + 1);
  localparam int ENT_W = ADDR_W + SZ_W + ORDER_W;

  localparam logic [SZ_W-1:0]   PagePayload = SZ_W'(PAGE_BYTES - HEADER_BYTES);
  localparam logic [SZ_W-1:0]   HdrSz       = SZ_W'(HEADER_BYTES);
  localparam logic [ADDR_W-1:0] HdrAd       = ADDR_W'(HEADER_BYTES);
  localparam logic [ADDR_W-1:0] PageAd      = ADDR_W'(PAGE_BYTES);
  localparam logic [IDX_W-1:0]  LastIdx     = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [PG_W-1:0]   PageLimit   = PG_W'(PAGES);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DRAIN, S_DECIDE, S_WR_T, S_WR_S, S_RESP
  } state_e;

  state_e                  state_q;
  logic [IDX_W-1:0]        idx_q, chk_idx_q;
  logic                    chk_vld_q;
  logic                    act_q;
  logic [SZ_W-1:0]         req_q;
  logic [ADDR_W-1:0]       addr_q;
  logic [TABLE_ENTRIES-1:0] valid_q, free_q;
  logic                    best_fnd_q;
  logic [IDX_W-1:0]        best_idx_q;
  logic [ADDR_W-1:0]       best_start_q;
  logic [SZ_W-1:0]         best_size_q;
  logic [ORDER_W-1:0]      best_ord_q;
  logic                    e1_fnd_q, e2_fnd_q;
  logic [IDX_W-1:0]        e1_q, e2_q;
  logic [IDX_W-1:0]        wr_t_q, wr_s_q;
  logic [ADDR_W-1:0]       base_q;
  logic [SZ_W-1:0]         rem_q;
  logic                    fresh_q, split_q;
  logic [ORDER_W-1:0]      cnt_q;
  logic [PG_W-1:0]         pages_q;
  logic [ADDR_W-1:0]       page_base_q;
  logic [ADDR_W-1:0]       pend_addr_q;
  logic                    pend_new_q;
  logic [STATUS_W-1:0]     pend_status_q;
  logic [ADDR_W-1:0]       res_addr_q;
  logic                    res_new_q;
  logic [STATUS_W-1:0]     res_status_q;
  logic                    out_vld_q;

  // table memory
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [ENT_W-1:0]        ram_wdata;
  logic [ENT_W-1:0]        ram_rdata;

  wfba_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (state_q == S_SCAN),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // per-entry evaluation
  logic [ADDR_W-1:0]  ent_start;
  logic [SZ_W-1:0]    ent_size;
  logic [ORDER_W-1:0] ent_ord;
  logic               ent_valid, ent_free, take;

  always_comb begin
    ent_start = ram_rdata[ENT_W-1 -: ADDR_W];
    ent_size  = ram_rdata[ORDER_W +: SZ_W];
    ent_ord   = ram_rdata[ORDER_W-1:0];
    ent_valid = valid_q[chk_idx_q];
    ent_free  = free_q[chk_idx_q];
    if (act_q == ACT_ALLOC) begin
      take = ent_valid && ent_free && (ent_size >= req_q) &&
             (!best_fnd_q || (ent_size > best_size_q) ||
              ((ent_size == best_size_q) && (ent_ord > best_ord_q)));
    end else begin
      take = ent_valid && !ent_free && !best_fnd_q &&
             ((ent_start + HdrAd) == addr_q);
    end
  end

  // allocation decision
  logic [ADDR_W-1:0] cand_start;
  logic [SZ_W-1:0]   cand_size, cand_rem;
  logic [IDX_W-1:0]  cand_t, cand_s;
  logic              cand_s_ok, cand_split, no_page, no_entry;

  always_comb begin
    cand_start = best_fnd_q ? best_start_q : page_base_q;
    cand_size  = best_fnd_q ? best_size_q : PagePayload;
    cand_t     = best_fnd_q ? best_idx_q : e1_q;
    cand_s     = best_fnd_q ? e1_q : e2_q;
    cand_s_ok  = best_fnd_q ? e1_fnd_q : e2_fnd_q;
    cand_rem   = cand_size - req_q;
    cand_split = cand_rem > HdrSz;
    no_page    = !best_fnd_q && ((req_q > PagePayload) || (pages_q >= PageLimit));
    no_entry   = (!best_fnd_q && !e1_fnd_q) || (cand_split && !cand_s_ok);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = best_idx_q;
    ram_wdata = {best_start_q, best_size_q, cnt_q};
    unique case (state_q)
      S_DECIDE: ram_we = (act_q == ACT_FREE) && best_fnd_q;
      S_WR_T: begin
        ram_we    = 1'b1;
        ram_waddr = wr_t_q;
        ram_wdata = {base_q, req_q, {ORDER_W{1'b0}}};
      end
      S_WR_S: begin
        ram_we    = 1'b1;
        ram_waddr = wr_s_q;
        ram_wdata = {base_q + HdrAd + ADDR_W'(req_q), rem_q - HdrSz, cnt_q};
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      idx_q         <= '0;
      chk_idx_q     <= '0;
      chk_vld_q     <= 1'b0;
      act_q         <= ACT_ALLOC;
      req_q         <= '0;
      addr_q        <= '0;
      valid_q       <= '0;
      free_q        <= '0;
      best_fnd_q    <= 1'b0;
      best_idx_q    <= '0;
      best_start_q  <= '0;
      best_size_q   <= '0;
      best_ord_q    <= '0;
      e1_fnd_q      <= 1'b0;
      e2_fnd_q      <= 1'b0;
      e1_q          <= '0;
      e2_q          <= '0;
      wr_t_q        <= '0;
      wr_s_q        <= '0;
      base_q        <= '0;
      rem_q         <= '0;
      fresh_q       <= 1'b0;
      split_q       <= 1'b0;
      cnt_q         <= '0;
      pages_q       <= '0;
      page_base_q   <= '0;
      pend_addr_q   <= '0;
      pend_new_q    <= 1'b0;
      pend_status_q <= ST_OK;
      res_addr_q    <= '0;
      res_new_q     <= 1'b0;
      res_status_q  <= ST_OK;
      out_vld_q     <= 1'b0;
    end else begin
      if (out_vld_q && rsp_o.ready && (state_q != S_RESP)) begin
        out_vld_q <= 1'b0;
      end

      // scan pipeline: entry read last cycle is checked now
      if (chk_vld_q) begin
        if (take) begin
          best_fnd_q   <= 1'b1;
          best_idx_q   <= chk_idx_q;
          best_start_q <= ent_start;
          best_size_q  <= ent_size;
          best_ord_q   <= ent_ord;
        end
        if (!ent_valid) begin
          if (!e1_fnd_q) begin
            e1_fnd_q <= 1'b1;
            e1_q     <= chk_idx_q;
          end else if (!e2_fnd_q) begin
            e2_fnd_q <= 1'b1;
            e2_q     <= chk_idx_q;
          end
        end
      end

      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            act_q      <= req_i.action;
            req_q      <= SZ_W'(req_i.request_size);
            addr_q     <= req_i.address;
            idx_q      <= '0;
            best_fnd_q <= 1'b0;
            e1_fnd_q   <= 1'b0;
            e2_fnd_q   <= 1'b0;
            state_q    <= S_SCAN;
          end
        end
        S_SCAN: begin
          chk_vld_q <= 1'b1;
          chk_idx_q <= idx_q;
          if (idx_q == LastIdx) begin
            state_q <= S_DRAIN;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_DRAIN: begin
          chk_vld_q <= 1'b0;
          state_q   <= S_DECIDE;
        end
        S_DECIDE: begin
          pend_addr_q <= '0;
          pend_new_q  <= 1'b0;
          state_q     <= S_RESP;
          if (act_q == ACT_FREE) begin
            if (best_fnd_q) begin
              free_q[best_idx_q] <= 1'b1;
              cnt_q              <= cnt_q + 1'b1;
              pend_status_q      <= ST_OK;
            end else begin
              pend_status_q <= ST_BAD_FREE;
            end
          end else begin
            priority if (no_page) begin
              pend_status_q <= ST_NO_PAGES;
            end else if (no_entry) begin
              pend_status_q <= ST_TABLE_FULL;
            end else begin
              pend_status_q <= ST_OK;
              wr_t_q        <= cand_t;
              wr_s_q        <= cand_s;
              base_q        <= cand_start;
              rem_q         <= cand_rem;
              fresh_q       <= !best_fnd_q;
              split_q       <= cand_split;
              state_q       <= S_WR_T;
            end
          end
        end
        S_WR_T: begin
          valid_q[wr_t_q] <= 1'b1;
          free_q[wr_t_q]  <= 1'b0;
          pend_addr_q     <= base_q + HdrAd;
          pend_new_q      <= fresh_q;
          if (fresh_q) begin
            pages_q     <= pages_q + 1'b1;
            page_base_q <= page_base_q + PageAd;
          end
          state_q <= split_q ? S_WR_S : S_RESP;
        end
        S_WR_S: begin
          valid_q[wr_s_q] <= 1'b1;
          free_q[wr_s_q]  <= 1'b1;
          cnt_q           <= cnt_q + 1'b1;
          state_q         <= S_RESP;
        end
        S_RESP: begin
          if (!out_vld_q || rsp_o.ready) begin
            out_vld_q    <= 1'b1;
            res_addr_q   <= pend_addr_q;
            res_new_q    <= pend_new_q;
            res_status_q <= pend_status_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.address_res = res_addr_q;
  assign rsp_o.new_page    = res_new_q;
  assign rsp_o.status      = res_status_q;

  // failed requests hand out no address; free requests return zero too, not checked here
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != ST_OK) |-> (rsp_o.address_res == '0))
    else $error("address on failed response");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.new_page) |-> (rsp_o.status == ST_OK))
    else $error("new page on failed response");

  // push stamps advance by one at most
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("push counter jumped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while busy");

  // page count only moves on a fresh-page table write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pages_q != $past(pages_q)) |-> ($past(state_q) == S_WR_T && $past(fresh_q)))
    else $error("page count changed outside allocation");

endmodule

### sv/wfba_ram.sv
module wfba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
